// ===== hdl/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg: shared definitions for the divisor count and sum block
// Widths, the prime table, the controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam int VALUE_W     = 20;
    localparam int COUNT_W     = 8;
    localparam int SUM_W       = 23;
    localparam int PRIME_LIMIT = 1000;
    localparam int PRIME_COUNT = 168;

    localparam int PRIME_W   = $clog2(PRIME_LIMIT);
    localparam int PIDX_W    = $clog2(PRIME_COUNT);
    localparam int IDX_W     = $clog2(PRIME_COUNT + 1);
    localparam int MULT_W    = $clog2(VALUE_W + 1);
    localparam int TERM_W    = VALUE_W + 1;
    localparam int CNT_ACC_W = COUNT_W + 1;
    localparam int SUM_ACC_W = SUM_W + 1;
    localparam int DIV_CNT_W = $clog2(VALUE_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    // primes below the prime limit, ascending
    localparam logic [PRIME_W-1:0] PRIME_ROM [PRIME_COUNT] = '{
        10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
        10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
        10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
        10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
        10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
        10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
        10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
        10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
        10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
        10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
        10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
        10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
        10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
        10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
        10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
        10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
        10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769,
        10'd773, 10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827,
        10'd829, 10'd839, 10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881,
        10'd883, 10'd887, 10'd907, 10'd911, 10'd919, 10'd929, 10'd937, 10'd941,
        10'd947, 10'd953, 10'd967, 10'd971, 10'd977, 10'd983, 10'd991, 10'd997
    };

    // past the end of the table reads as zero
    function automatic logic [PRIME_W-1:0] prime_at(input logic [IDX_W-1:0] idx);
        logic [PRIME_W-1:0] p;
        p = '0;
        if (idx < IDX_W'(PRIME_COUNT))
        begin
            p = PRIME_ROM[idx[PIDX_W-1:0]];
        end
        return p;
    endfunction

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SQ    = 9'b000000010,
        S_CHECK = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_HIT   = 9'b000010000,
        S_TERM  = 9'b000100000,
        S_NEXT  = 9'b001000000,
        S_TAIL  = 9'b010000000,
        S_FIN   = 9'b100000000
    } dcs_state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic div_start;
        logic hit;
        logic term;
        logic next;
        logic tail;
        logic out_load;
    } dcs_cmd_t;

    typedef struct packed {
        logic stop;
        logic div_done;
        logic div_exact;
    } dcs_sts_t;

endpackage

// ===== hdl/dcs_in_if.sv =====
// ----------------------------------------------------------------------------
// dcs_in_if: request channel of the divisor count and sum block
// Carries one value per request with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface dcs_in_if import dcs_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

// ===== hdl/dcs_out_if.sv =====
// ----------------------------------------------------------------------------
// dcs_out_if: result channel of the divisor count and sum block
// Carries the divisor count and divisor sum with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface dcs_out_if import dcs_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] divisor_count;
    logic [SUM_W-1:0]   divisor_sum;

    modport source (output valid, output divisor_count, output divisor_sum, input ready);
    modport sink   (input valid, input divisor_count, input divisor_sum, output ready);

endinterface

// ===== hdl/dcs_div.sv =====
// ----------------------------------------------------------------------------
// dcs_div: serial restoring divider
// Divides the remaining cofactor by a table prime, one quotient bit a cycle,
// and pulses done with quotient and remainder held.
// ----------------------------------------------------------------------------
module dcs_div import dcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [PRIME_W-1:0] divisor,
    output logic               done,
    output logic [VALUE_W-1:0] quotient,
    output logic [PRIME_W-1:0] remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   quo_reg, quo_next;
    logic [PRIME_W-1:0]   rem_reg, rem_next;
    logic [PRIME_W-1:0]   div_reg, div_next;
    logic [PRIME_W:0]     trial;
    logic [PRIME_W:0]     diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[VALUE_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];
            quo_next = {quo_reg[VALUE_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== hdl/dcs_datapath.sv =====
// ----------------------------------------------------------------------------
// dcs_datapath: factoring datapath
// Holds the cofactor, prime index, multiplicity, power and running count and
// sum, with the serial divider and the output registers.
// ----------------------------------------------------------------------------
module dcs_datapath import dcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dcs_cmd_t           cmd,
    output dcs_sts_t           sts,
    input  logic [VALUE_W-1:0] value,
    output logic [COUNT_W-1:0] divisor_count,
    output logic [SUM_W-1:0]   divisor_sum
);

    logic [VALUE_W-1:0]   rest_reg, rest_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [PRIME_W-1:0]   p_reg, p_next;
    logic [VALUE_W-1:0]   psq_reg, psq_next;
    logic [MULT_W-1:0]    mult_reg, mult_next;
    logic [VALUE_W-1:0]   power_reg, power_next;
    logic [TERM_W-1:0]    term_reg, term_next;
    logic [CNT_ACC_W-1:0] count_reg, count_next;
    logic [SUM_ACC_W-1:0] sum_reg, sum_next;
    logic                 zero_reg, zero_next;
    logic [COUNT_W-1:0]   ocount_reg, ocount_next;
    logic [SUM_W-1:0]     osum_reg, osum_next;

    logic [PRIME_W-1:0]           rom_p;
    logic [2*PRIME_W-1:0]         rom_sq;
    logic [VALUE_W+PRIME_W-1:0]   power_prod;
    logic [CNT_ACC_W+MULT_W-1:0]  count_prod;
    logic [SUM_ACC_W+TERM_W-1:0]  sum_prod;
    logic [SUM_ACC_W+TERM_W-1:0]  tail_prod;
    logic [MULT_W-1:0]            mult_inc;
    logic [TERM_W-1:0]            rest_inc;
    logic                         div_done;
    logic [VALUE_W-1:0]           div_quo;
    logic [PRIME_W-1:0]           div_rem;

    dcs_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rest_reg),
        .divisor   (p_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign rom_p      = prime_at(idx_reg);
    assign rom_sq     = rom_p * rom_p;
    assign power_prod = power_reg * p_reg;
    assign mult_inc   = mult_reg + 1'b1;
    assign count_prod = count_reg * mult_inc;
    assign sum_prod   = sum_reg * term_reg;
    assign rest_inc   = {1'b0, rest_reg} + 1'b1;
    assign tail_prod  = sum_reg * rest_inc;

    always_comb
    begin
        rest_next   = rest_reg;
        idx_next    = idx_reg;
        p_next      = p_reg;
        psq_next    = psq_reg;
        mult_next   = mult_reg;
        power_next  = power_reg;
        term_next   = term_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        zero_next   = zero_reg;
        ocount_next = ocount_reg;
        osum_next   = osum_reg;
        if (cmd.load)
        begin
            rest_next  = value;
            idx_next   = '0;
            mult_next  = '0;
            power_next = VALUE_W'(1);
            term_next  = TERM_W'(1);
            count_next = CNT_ACC_W'(1);
            sum_next   = SUM_ACC_W'(1);
            zero_next  = (value == '0);
        end
        if (cmd.square)
        begin
            p_next   = rom_p;
            psq_next = rom_sq[VALUE_W-1:0];
        end
        if (cmd.hit)
        begin
            rest_next  = div_quo;
            mult_next  = mult_inc;
            power_next = power_prod[VALUE_W-1:0];
        end
        if (cmd.term)
        begin
            term_next = term_reg + {1'b0, power_reg};
        end
        if (cmd.next)
        begin
            if (mult_reg != '0)
            begin
                count_next = count_prod[CNT_ACC_W-1:0];
                sum_next   = sum_prod[SUM_ACC_W-1:0];
            end
            idx_next   = idx_reg + 1'b1;
            mult_next  = '0;
            power_next = VALUE_W'(1);
            term_next  = TERM_W'(1);
        end
        // a cofactor above one left over is taken as one more prime
        if (cmd.tail && (rest_reg > VALUE_W'(1)))
        begin
            count_next = {count_reg[CNT_ACC_W-2:0], 1'b0};
            sum_next   = tail_prod[SUM_ACC_W-1:0];
        end
        if (cmd.out_load)
        begin
            if (zero_reg)
            begin
                ocount_next = '0;
                osum_next   = '0;
            end
            else
            begin
                ocount_next = (count_reg > CNT_ACC_W'(COUNT_MAX)) ? COUNT_MAX
                                                                  : count_reg[COUNT_W-1:0];
                osum_next   = (sum_reg > SUM_ACC_W'(SUM_MAX)) ? SUM_MAX
                                                              : sum_reg[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            zero_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            zero_reg <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg   <= rest_next;
        p_reg      <= p_next;
        psq_reg    <= psq_next;
        mult_reg   <= mult_next;
        power_reg  <= power_next;
        term_reg   <= term_next;
        count_reg  <= count_next;
        sum_reg    <= sum_next;
        ocount_reg <= ocount_next;
        osum_reg   <= osum_next;
    end

    // stop at the end of the table or once p squared passes the cofactor
    assign sts.stop      = (idx_reg == IDX_W'(PRIME_COUNT)) || (psq_reg > rest_reg);
    assign sts.div_done  = div_done;
    assign sts.div_exact = (div_rem == '0);

    assign divisor_count = ocount_reg;
    assign divisor_sum   = osum_reg;

endmodule

// ===== hdl/dcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcs_ctrl: sequencer for trial division
// Steps through square check, division, factor update and the final fold,
// and runs the request and result handshakes.
// ----------------------------------------------------------------------------
module dcs_ctrl import dcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    output dcs_cmd_t cmd,
    input  dcs_sts_t sts
);

    dcs_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.stop)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = sts.div_exact ? S_HIT : S_NEXT;
                end
            end
            S_HIT:
            begin
                cmd.hit    = 1'b1;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                // divide the reduced cofactor by the same prime again
                cmd.term      = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_NEXT:
            begin
                cmd.next   = 1'b1;
                state_next = S_SQ;
            end
            S_TAIL:
            begin
                cmd.tail   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

`ifndef SYNTH
    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || result_ready))
        else $error("result loaded over a pending result");
    a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == S_SQ))
        else $error("accepted request did not start the prime walk");
    a_done_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule

// ===== hdl/divisor_count_and_sum.sv =====
// ----------------------------------------------------------------------------
// divisor_count_and_sum: divisor count and divisor sum of one integer
// Factors each value by trial division over the primes below 1000 and
// returns the number and the sum of its divisors.
// ----------------------------------------------------------------------------
// One value is handled at a time. Each prime tried goes through the square
// check, a 20-step one-bit-per-cycle divide and the fold into count and sum;
// each repeated factor found adds another divide, the start and the final
// fold come on top, and the worst case walks all 168 primes. The serial
// divider sets the pace. A finished result waits in an output register, so
// the next value is taken while it is still pending. A zero input gives zero
// for both results.
module divisor_count_and_sum import dcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dcs_in_if.sink    item,
    dcs_out_if.source result
);

    dcs_cmd_t cmd;
    dcs_sts_t sts;

    dcs_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    dcs_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .value         (item.value),
        .divisor_count (result.divisor_count),
        .divisor_sum   (result.divisor_sum)
    );

endmodule
